@@ design/sfr_pkg.sv @@
// Shared types, constants and the microcode table of the subtitle page framer.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

   localparam int STEP_W = 4;

   // program steps
   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DIV     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SYNC    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TYPE    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_PAGE_HI = 4'd4;
   localparam logic [STEP_W-1:0] STEP_PAGE_LO = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_TIMEOUT = 4'd8;
   localparam logic [STEP_W-1:0] STEP_VERSION = 4'd9;
   localparam logic [STEP_W-1:0] STEP_INDEX   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_RSVD    = 4'd11;
   localparam logic [STEP_W-1:0] STEP_X_HI    = 4'd12;
   localparam logic [STEP_W-1:0] STEP_X_LO    = 4'd13;
   localparam logic [STEP_W-1:0] STEP_Y_HI    = 4'd14;
   localparam logic [STEP_W-1:0] STEP_Y_LO    = 4'd15;

   // configuration register indexes
   localparam logic CSR_OVERRIDE_X = 1'b0;
   localparam logic CSR_OVERRIDE_Y = 1'b1;

   localparam logic [7:0]  SYNC_BYTE        = 8'h0f;
   localparam logic [7:0]  SEGMENT_TYPE     = 8'h10;
   localparam logic [15:0] PAGE_ID          = 16'h0001;
   localparam int          BYTES_PER_REGION = 6;
   localparam int          LEN_BASE         = 2;
   localparam logic [1:0]  STATE_CHANGED    = 2'd2;
   localparam logic [1:0]  STATE_NORMAL     = 2'd1;

   localparam int TIME_W   = 48;
   localparam int US_PER_S = 1000000;

   // one million is 64 * 15625: drop six low bits, then multiply by 2^56 / 15625
   // rounded up; the rounding error stays below one for every 42-bit value
   localparam int             DIV_SHIFT = 6;
   localparam int             RCP_SHIFT = 56;
   localparam int             RCP_W     = 43;
   localparam logic [RCP_W-1:0] RCP_MUL =
      RCP_W'(((64'd1 << (RCP_SHIFT + DIV_SHIFT)) / 64'(US_PER_S)) + 64'd1);

   typedef enum logic [3:0] {
      BS_SYNC,
      BS_TYPE,
      BS_PAGE_HI,
      BS_PAGE_LO,
      BS_LEN_HI,
      BS_LEN_LO,
      BS_TIMEOUT,
      BS_VERSION,
      BS_INDEX,
      BS_ZERO,
      BS_X_HI,
      BS_X_LO,
      BS_Y_HI,
      BS_Y_LO
   } bsel_type;

   typedef enum logic [1:0] {
      HK_NONE,
      HK_ITEM,
      HK_DIV,
      HK_EMIT
   } hold_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_END_IF_EMPTY,
      BR_LOOP
   } br_type;

   typedef struct packed {
      logic              tready;
      logic              emit;
      bsel_type          bsel;
      hold_type          hold;
      br_type            br;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      ctrl_type ctrl;
      logic     advance;
      logic     page_done;
   } seq_type;

   typedef struct packed {
      logic item_last;
      logic div_done;
      logic emit_ok;
      logic no_regions;
      logic region_last;
   } stat_type;

   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type c;
      c = '{1'b0, 1'b1, BS_ZERO, HK_EMIT, BR_NEXT, STEP_IDLE};
      case (step)
         STEP_IDLE:    c = '{1'b1, 1'b0, BS_ZERO, HK_ITEM, BR_NEXT, STEP_IDLE};
         STEP_DIV:     c = '{1'b0, 1'b0, BS_ZERO, HK_DIV, BR_NEXT, STEP_IDLE};
         STEP_SYNC:    c.bsel = BS_SYNC;
         STEP_TYPE:    c.bsel = BS_TYPE;
         STEP_PAGE_HI: c.bsel = BS_PAGE_HI;
         STEP_PAGE_LO: c.bsel = BS_PAGE_LO;
         STEP_LEN_HI:  c.bsel = BS_LEN_HI;
         STEP_LEN_LO:  c.bsel = BS_LEN_LO;
         STEP_TIMEOUT: c.bsel = BS_TIMEOUT;
         STEP_VERSION: begin
            c.bsel = BS_VERSION;
            c.br   = BR_END_IF_EMPTY;
         end
         STEP_INDEX:   c.bsel = BS_INDEX;
         STEP_RSVD:    c.bsel = BS_ZERO;
         STEP_X_HI:    c.bsel = BS_X_HI;
         STEP_X_LO:    c.bsel = BS_X_LO;
         STEP_Y_HI:    c.bsel = BS_Y_HI;
         STEP_Y_LO: begin
            c.bsel   = BS_Y_LO;
            c.br     = BR_LOOP;
            c.target = STEP_INDEX;
         end
         default:      c = '{1'b1, 1'b0, BS_ZERO, HK_ITEM, BR_NEXT, STEP_IDLE};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ design/sfr_div.sv @@
// Timeout divider: page duration over one million by reciprocal multiply, low quotient byte.
`timescale 1ns / 1ps
`default_nettype none

module sfr_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [sfr_pkg::TIME_W-1:0] dividend,
   output logic                            done,
   output logic [7:0]                      quotient
);
   import sfr_pkg::*;

   localparam int N_W   = TIME_W - DIV_SHIFT;
   localparam int NL_W  = N_W / 2;
   localparam int ML_W  = RCP_W - NL_W;
   localparam int OP_W  = NL_W + ML_W;
   localparam int ACC_W = RCP_SHIFT + 8;

   // partial product order: low by low, low by high, high by low, high by high
   localparam logic [1:0] PH_LO_LO = 2'd0;
   localparam logic [1:0] PH_LO_HI = 2'd1;
   localparam logic [1:0] PH_HI_LO = 2'd2;
   localparam logic [1:0] PH_HI_HI = 2'd3;

   logic              busy_ff, busy_in;
   logic [1:0]        phase_ff, phase_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [NL_W-1:0]   op_a;
   logic [ML_W-1:0]   op_b;
   logic [OP_W-1:0]   prod;
   logic [ACC_W-1:0]  addend;

   assign op_a = (phase_ff inside {PH_HI_LO, PH_HI_HI}) ? n_ff[N_W-1:NL_W] : n_ff[NL_W-1:0];
   assign op_b = (phase_ff inside {PH_LO_HI, PH_HI_HI}) ? ML_W'(RCP_MUL[RCP_W-1:ML_W])
                                                        : RCP_MUL[ML_W-1:0];
   assign prod = OP_W'(op_a) * OP_W'(op_b);

   // bits above the accumulator are dropped; only the low quotient byte is kept
   always_comb begin
      case (phase_ff)
         PH_LO_LO: addend = ACC_W'(prod);
         PH_LO_HI: addend = ACC_W'(prod) << ML_W;
         PH_HI_LO: addend = ACC_W'(prod) << NL_W;
         default:  addend = ACC_W'(prod) << (NL_W + ML_W);
      endcase
   end

   assign done     = busy_ff && (phase_ff == PH_HI_HI);
   assign quotient = acc_ff[ACC_W-1:RCP_SHIFT];

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      n_in     = n_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_LO_LO;
         n_in     = dividend[TIME_W-1:DIV_SHIFT];
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = acc_ff + addend;
         phase_in = phase_ff + 2'd1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_LO_LO;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      n_ff   <= n_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

@@ design/sfr_seq.sv @@
// Microcode sequencer: step counter, control table lookup and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module sfr_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sfr_pkg::stat_type stat,
   output sfr_pkg::seq_type       seq
);
   import sfr_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_type          ctrl;
   logic              go;
   logic              finish;

   assign ctrl = ucode(step_ff);

   always_comb begin
      case (ctrl.hold)
         HK_ITEM: go = stat.item_last;
         HK_DIV:  go = stat.div_done;
         HK_EMIT: go = stat.emit_ok;
         default: go = 1'b1;
      endcase
   end

   always_comb begin
      finish = 1'b0;
      case (ctrl.br)
         BR_END_IF_EMPTY: finish = stat.no_regions;
         BR_LOOP:         finish = stat.region_last;
         default:         finish = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (go) begin
         if (finish) begin
            step_in = STEP_IDLE;
         end else if (ctrl.br == BR_LOOP) begin
            step_in = ctrl.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   assign seq.ctrl      = ctrl;
   assign seq.advance   = go;
   assign seq.page_done = go && finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ design/subtitle_page_composition_framer.sv @@
// Top level of the subtitle page composition framer: region table, byte datapath, output stage.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  req     | in        | req_tvalid/req_tready  | req_tdata region fields, req_tuser, tlast
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata segment byte, rsp_tuser, tlast
//  csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// Region items without last are taken back to back.
// After a page's last item, the timeout divider accumulates its partial products, then the
// segment bytes (8 + 6 per region) are stored in the output register, one per cycle unless
// the output is stalled. The next item is taken the cycle after the last byte is stored.
// Reset is synchronous, active high, and clears the size table and all control state.
`timescale 1ns / 1ps
`default_nettype none

module subtitle_page_composition_framer #(
   parameter int MAX_REGIONS = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [11:0] region_width, [23:12] region_height, [39:24] region_x, [55:40] region_y,
   // [103:56] start_time, [151:104] stop_time, [152] ephemeral, [159:153] zero
   input  wire logic [159:0] req_tdata,
   // [0] has_region
   input  wire logic         req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [7:0] out_byte
   output logic [7:0]        rsp_tdata,
   // [0] regions_dropped
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);
   import sfr_pkg::*;

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   logic [11:0]       in_w, in_h;
   logic [15:0]       in_x, in_y;
   logic [TIME_W-1:0] in_t0, in_t1;
   logic              in_eph;

   assign in_w   = req_tdata[11:0];
   assign in_h   = req_tdata[23:12];
   assign in_x   = req_tdata[39:24];
   assign in_y   = req_tdata[55:40];
   assign in_t0  = req_tdata[103:56];
   assign in_t1  = req_tdata[151:104];
   assign in_eph = req_tdata[152];

   seq_type  seq;
   stat_type stat;

   logic [15:0]      ovr_x_ff, ovr_y_ff;
   logic [11:0]      known_w_ff [MAX_REGIONS];
   logic [11:0]      known_h_ff [MAX_REGIONS];
   logic [15:0]      page_x_ff  [MAX_REGIONS];
   logic [15:0]      page_y_ff  [MAX_REGIONS];
   logic [3:0]       version_ff;
   logic             mode_ff;
   logic             over_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic             rsp_drop_ff;

   logic             req_fire;
   logic             has_room;
   logic [IDX_W-1:0] wr_idx;
   logic             width_new, height_grow;
   logic [TIME_W:0]  span;
   logic [TIME_W-1:0] dividend;
   logic             div_done;
   logic [7:0]       timeout;
   logic [15:0]      seg_len;
   logic             ovr;
   logic [15:0]      pos_x, pos_y;
   logic [1:0]       page_state;
   logic [7:0]       byte_val;
   logic             byte_last;

   assign req_tready = seq.ctrl.tready;
   assign req_fire   = req_tvalid && req_tready;
   assign has_room   = count_ff < CNT_W'(MAX_REGIONS);
   assign wr_idx     = count_ff[IDX_W-1:0];
   assign width_new  = known_w_ff[wr_idx] != in_w;
   assign height_grow = known_h_ff[wr_idx] < in_h;

   // zero timeout when ephemeral or stop does not follow start
   assign span     = {1'b0, in_t1} - {1'b0, in_t0};
   assign dividend = (in_eph || span[TIME_W]) ? '0 : span[TIME_W-1:0];

   sfr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire && req_tlast),
      .dividend (dividend),
      .done     (div_done),
      .quotient (timeout)
   );

   assign stat.item_last   = req_fire && req_tlast;
   assign stat.div_done    = div_done;
   assign stat.emit_ok     = seq.ctrl.emit && (!rsp_valid_ff || rsp_tready);
   assign stat.no_regions  = count_ff == '0;
   assign stat.region_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   sfr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .seq   (seq)
   );

   assign seg_len    = 16'(count_ff) * 16'(BYTES_PER_REGION) + 16'(LEN_BASE);
   assign ovr        = (ovr_x_ff != '0) && (ovr_y_ff != '0);
   assign pos_x      = ovr ? ovr_x_ff : page_x_ff[idx_ff];
   assign pos_y      = ovr ? ovr_y_ff : page_y_ff[idx_ff];
   assign page_state = mode_ff ? STATE_CHANGED : STATE_NORMAL;

   always_comb begin
      case (seq.ctrl.bsel)
         BS_SYNC:    byte_val = SYNC_BYTE;
         BS_TYPE:    byte_val = SEGMENT_TYPE;
         BS_PAGE_HI: byte_val = PAGE_ID[15:8];
         BS_PAGE_LO: byte_val = PAGE_ID[7:0];
         BS_LEN_HI:  byte_val = seg_len[15:8];
         BS_LEN_LO:  byte_val = seg_len[7:0];
         BS_TIMEOUT: byte_val = timeout;
         BS_VERSION: byte_val = {version_ff, page_state, 2'b00};
         BS_INDEX:   byte_val = 8'(idx_ff);
         BS_X_HI:    byte_val = pos_x[15:8];
         BS_X_LO:    byte_val = pos_x[7:0];
         BS_Y_HI:    byte_val = pos_y[15:8];
         BS_Y_LO:    byte_val = pos_y[7:0];
         default:    byte_val = 8'h00;
      endcase
   end

   assign byte_last = ((seq.ctrl.br == BR_END_IF_EMPTY) && stat.no_regions)
                   || ((seq.ctrl.br == BR_LOOP) && stat.region_last);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_x_ff <= '0;
         ovr_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OVERRIDE_X: ovr_x_ff <= csr_wdata;
            CSR_OVERRIDE_Y: ovr_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // remembered region sizes persist across pages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_REGIONS; i++) begin
            known_w_ff[i] <= '0;
            known_h_ff[i] <= '0;
         end
      end else if (req_fire && req_tuser && has_room) begin
         if (width_new) begin
            known_w_ff[wr_idx] <= in_w;
         end
         if (height_grow) begin
            known_h_ff[wr_idx] <= in_h;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser && has_room) begin
         page_x_ff[wr_idx] <= in_x;
         page_y_ff[wr_idx] <= in_y;
      end
   end

   // page bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= '0;
         mode_ff    <= 1'b0;
         over_ff    <= 1'b0;
         count_ff   <= '0;
         idx_ff     <= '0;
      end else if (seq.page_done) begin
         version_ff <= version_ff + 4'd1;
         mode_ff    <= 1'b0;
         over_ff    <= 1'b0;
         count_ff   <= '0;
         idx_ff     <= '0;
      end else begin
         if (req_fire && req_tuser) begin
            if (has_room) begin
               count_ff <= count_ff + CNT_W'(1);
               if (width_new || height_grow) begin
                  mode_ff <= 1'b1;
               end
            end else begin
               over_ff <= 1'b1;
            end
         end
         // advance to the next region after its last byte
         if (seq.advance && (seq.ctrl.br == BR_LOOP)) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   // output register: hold until taken, refill in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.emit_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.emit_ok) begin
         rsp_byte_ff <= byte_val;
         rsp_last_ff <= byte_last;
         rsp_drop_ff <= over_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_drop_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REGIONS))
      else $error("region count beyond table depth");

   a_final_byte_ends_page: assert property (@(posedge clock) disable iff (reset)
      (stat.emit_ok && byte_last) |-> seq.page_done)
      else $error("final segment byte stored without closing the page");

   a_page_cleared: assert property (@(posedge clock) disable iff (reset)
      seq.page_done |=> (count_ff == '0) && !mode_ff && !over_ff && (idx_ff == '0))
      else $error("page state not cleared after emission");

   a_version_step: assert property (@(posedge clock) disable iff (reset)
      seq.page_done |=> version_ff == ($past(version_ff) + 4'd1))
      else $error("page version did not advance");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (div_done || stat.emit_ok) |-> !req_tready)
      else $error("input taken while a segment is in progress");
`endif

endmodule

`default_nettype wire

@@ sim/subtitle_page_composition_framer_test.sv @@
// Self-checking testbench for the subtitle page composition framer: directed tests and random pages vs. a predictor.
`timescale 1ns / 1ps

module subtitle_page_composition_framer_test;
   import sfr_pkg::*;

   localparam int SLOTS      = 8;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 410;

   typedef struct {
      bit        has;
      bit [11:0] w;
      bit [11:0] h;
      bit [15:0] x;
      bit [15:0] y;
      bit [47:0] t0;
      bit [47:0] t1;
      bit        eph;
      bit        last;
   } page_item_type;

   typedef struct {
      bit [7:0] data;
      bit       last;
      bit       dropped;
   } seg_byte_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_OVERRIDE_X;
   logic [15:0]  csr_wdata = '0;

   subtitle_page_composition_framer #(.MAX_REGIONS(SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   bit [11:0] size_w [SLOTS];
   bit [11:0] size_h [SLOTS];
   bit [15:0] slot_x [SLOTS];
   bit [15:0] slot_y [SLOTS];
   bit [3:0]  seg_version;
   bit        size_changed;
   int        slots_used;
   bit        page_dropped;
   bit [15:0] force_x;
   bit [15:0] force_y;

   seg_byte_type expected_bytes[$];
   int        mismatch_count = 0;
   int        items_sent = 0;
   int        burst_left = 0;
   int        idle_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void predict_segment(input page_item_type it);
      bit [47:0] span;
      bit [7:0]  timeout;
      bit [15:0] seg_len;
      bit [1:0]  page_state;
      bit        use_force;
      bit [15:0] px;
      bit [15:0] py;
      bit [7:0]  seg[$];
      seg_byte_type e;
      if (it.has) begin
         if (slots_used < SLOTS) begin
            if (size_w[slots_used] != it.w) begin
               size_changed = 1'b1;
               size_w[slots_used] = it.w;
            end
            if (size_h[slots_used] < it.h) begin
               size_changed = 1'b1;
               size_h[slots_used] = it.h;
            end
            slot_x[slots_used] = it.x;
            slot_y[slots_used] = it.y;
            slots_used++;
         end else begin
            page_dropped = 1'b1;
         end
      end
      if (!it.last) return;

      timeout = '0;
      if (!it.eph && it.t1 > it.t0) begin
         span = it.t1 - it.t0;
         timeout = 8'(span / 48'(US_PER_S));
      end
      seg_len    = 16'(slots_used * BYTES_PER_REGION + LEN_BASE);
      page_state = size_changed ? STATE_CHANGED : STATE_NORMAL;
      use_force  = (force_x != 0) && (force_y != 0);

      seg.push_back(SYNC_BYTE);
      seg.push_back(SEGMENT_TYPE);
      seg.push_back(PAGE_ID[15:8]);
      seg.push_back(PAGE_ID[7:0]);
      seg.push_back(seg_len[15:8]);
      seg.push_back(seg_len[7:0]);
      seg.push_back(timeout);
      seg.push_back({seg_version, page_state, 2'b00});
      for (int i = 0; i < slots_used; i++) begin
         px = use_force ? force_x : slot_x[i];
         py = use_force ? force_y : slot_y[i];
         seg.push_back(8'(i));
         seg.push_back(8'h00);
         seg.push_back(px[15:8]);
         seg.push_back(px[7:0]);
         seg.push_back(py[15:8]);
         seg.push_back(py[7:0]);
      end
      foreach (seg[i]) begin
         e.data    = seg[i];
         e.last    = (i == seg.size() - 1);
         e.dropped = page_dropped;
         expected_bytes.push_back(e);
      end

      seg_version++;
      slots_used   = 0;
      size_changed = 1'b0;
      page_dropped = 1'b0;
   endfunction

   function automatic page_item_type blank_item();
      page_item_type it;
      it = '{default: '0};
      return it;
   endfunction

   // Send one item in bursts with random gaps; predict on acceptance.
   task automatic send_item(input page_item_type it);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, it.eph, it.t1, it.t0, it.y, it.x, it.h, it.w};
      req_tuser  <= it.has;
      req_tlast  <= it.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_segment(it);
      items_sent++;
   endtask

   // Drop valid and wait until every expected byte has come back, then let the block settle.
   task automatic drain_segments();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_overrides(input bit [15:0] ox, input bit [15:0] oy);
      drain_segments();
      csr_we    <= 1'b1;
      csr_index <= CSR_OVERRIDE_X;
      csr_wdata <= ox;
      @(posedge clock);
      force_x = ox;
      csr_index <= CSR_OVERRIDE_Y;
      csr_wdata <= oy;
      @(posedge clock);
      force_y = oy;
      csr_we <= 1'b0;
   endtask

   task automatic send_page(input bit [11:0] w0, input bit [11:0] h0,
                            input bit [11:0] w1, input bit [11:0] h1, input int n);
      page_item_type it;
      it = blank_item();
      it.has = 1'b1;
      it.t1  = 48'd7_500_000;
      for (int r = 0; r < n; r++) begin
         it.w    = (r == 0) ? w0 : w1;
         it.h    = (r == 0) ? h0 : h1;
         it.x    = 16'($urandom);
         it.y    = 16'($urandom);
         it.last = (r == n - 1);
         send_item(it);
      end
   endtask

   task automatic test_field_extremes();
      page_item_type it;
      it = blank_item();
      it.has = 1'b1; it.w = '1; it.h = '1; it.x = '1; it.y = '1;
      it.t0 = '0; it.t1 = '1; it.last = 1'b1;
      send_item(it);
      // width shrinks to zero: mode change; stop before start gives zero timeout
      it = blank_item();
      it.has = 1'b1; it.t0 = '1; it.t1 = '0; it.last = 1'b1;
      send_item(it);
   endtask

   task automatic test_size_tracking();
      send_page(12'd100, 12'd50, 12'd200, 12'd80, 2);
      send_page(12'd100, 12'd20, 12'd200, 12'd80, 2);
      send_page(12'd100, 12'd51, 12'd0, 12'd0, 1);
   endtask

   task automatic test_empty_items();
      page_item_type it;
      it = blank_item();
      send_item(it);
      it.last = 1'b1;
      send_item(it);
      send_page(12'd100, 12'd10, 12'd0, 12'd0, 1);
      it = blank_item();
      it.has = 1'b1; it.w = 12'd100; it.h = 12'd5;
      send_item(it);
      it.has = 1'b0; it.last = 1'b1; it.t1 = 48'd3_000_000;
      send_item(it);
   endtask

   task automatic test_timeout_cases();
      page_item_type it;
      bit [47:0] spans [5];
      spans = '{48'd5_000_000, 48'd0, 48'd255_999_999, 48'd256_000_000, 48'd999_999};
      it = blank_item();
      it.has = 1'b1; it.w = 12'd100; it.h = 12'd1; it.last = 1'b1;
      it.t0 = 48'h8000_0000_1234;
      foreach (spans[i]) begin
         it.t1  = it.t0 + spans[i];
         it.eph = (i == 0);
         send_item(it);
      end
   endtask

   task automatic test_region_overflow();
      page_item_type it;
      it = blank_item();
      it.has = 1'b1;
      it.t1  = 48'd42_000_000;
      for (int r = 0; r < 10; r++) begin
         it.w    = 12'(r * 300);
         it.h    = 12'(r * 200);
         it.x    = 16'($urandom);
         it.y    = 16'($urandom);
         it.last = (r == 9);
         send_item(it);
      end
   endtask

   task automatic test_overrides();
      bit [15:0] ox [5];
      bit [15:0] oy [5];
      ox = '{16'h1234, 16'h0000, 16'hffff, 16'h0001, 16'h0000};
      oy = '{16'h0000, 16'habcd, 16'hffff, 16'h0001, 16'h0000};
      foreach (ox[i]) begin
         program_overrides(ox[i], oy[i]);
         send_page(12'd321, 12'd9, 12'd654, 12'd7, 2);
      end
   endtask

   function automatic bit [15:0] pick_override();
      case ($urandom_range(0, 7))
         0, 1:    return 16'h0000;
         2:       return 16'hffff;
         3:       return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_page();
      page_item_type it;
      int         n;
      bit         tail_empty;
      case ($urandom_range(0, 9))
         0:       n = 0;
         1, 2:    n = $urandom_range(SLOTS + 1, SLOTS + 3);
         default: n = $urandom_range(1, SLOTS);
      endcase
      tail_empty = (n == 0) || ($urandom_range(0, 6) == 0);
      for (int r = 0; r < n + tail_empty; r++) begin
         // occasional ignored item between regions
         if ($urandom_range(0, 9) == 0) begin
            it = blank_item();
            it.w = 12'($urandom); it.x = 16'($urandom);
            send_item(it);
         end
         it = blank_item();
         it.has = (r < n);
         if (r < SLOTS && $urandom_range(0, 2) != 0) begin
            // reuse the remembered size so that pages without a mode change occur
            it.w = size_w[r];
            it.h = ($urandom_range(0, 3) == 0) ? size_h[r] + 12'd1
                                              : 12'($urandom_range(0, size_h[r]));
         end else if ($urandom_range(0, 1) == 0) begin
            it.w = 12'($urandom);
            it.h = 12'($urandom);
         end else begin
            it.w = 12'($urandom_range(0, 3));
            it.h = 12'($urandom_range(0, 3));
         end
         it.x   = 16'($urandom);
         it.y   = 16'($urandom);
         it.t0  = 48'({$urandom, $urandom});
         it.eph = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 5))
            0:       it.t1 = it.t0;
            1:       it.t1 = 48'({$urandom, $urandom});
            2:       it.t1 = it.t0 + 48'($urandom_range(0, 300_000_000));
            3:       it.t1 = it.t0 + 48'({$urandom_range(0, 65535), $urandom});
            4:       it.t1 = it.t0 - 48'($urandom_range(1, 5_000_000));
            default: it.t1 = it.t0 + 48'($urandom_range(0, 300)) * 48'(US_PER_S)
                             + (($urandom_range(0, 1) == 0) ? 48'd0 : 48'(US_PER_S - 1));
         endcase
         it.last = (r == n + tail_empty - 1);
         send_item(it);
      end
   endtask

   task automatic test_random_pages();
      int target;
      int pages;
      target = items_sent + RANDOM_ITEMS;
      pages  = 0;
      while (items_sent < target) begin
         if (pages % 12 == 11) program_overrides(pick_override(), pick_override());
         send_random_page();
         pages++;
      end
   endtask

   initial begin
      size_w       = '{default: '0};
      size_h       = '{default: '0};
      slot_x       = '{default: '0};
      slot_y       = '{default: '0};
      seg_version  = '0;
      size_changed = 1'b0;
      slots_used   = 0;
      page_dropped = 1'b0;
      force_x      = '0;
      force_y      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_size_tracking();
      test_empty_items();
      test_timeout_cases();
      test_region_overflow();
      test_overrides();
      test_random_pages();

      drain_segments();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   function automatic void flag_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
   endfunction

   // receiver stall pattern: free running, random, periodic, or mostly stalled
   int stall_mode = 0;
   int stall_left = 0;
   int stall_period = 1;
   int stall_phase = 0;

   always @(posedge clock) begin : byte_check
      seg_byte_type want;
      bit        ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               flag_mismatch("byte with nothing pending", 0, rsp_tdata);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data) flag_mismatch("out_byte", want.data, rsp_tdata);
               if (rsp_tlast !== want.last) flag_mismatch("last_byte", want.last, rsp_tlast);
               if (rsp_tuser !== want.dropped)
                  flag_mismatch("regions_dropped", want.dropped, rsp_tuser);
            end
         end
         if (stall_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 6);
         end
         stall_left--;
         stall_phase = (stall_phase + 1) % stall_period;
         case (stall_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = $urandom_range(0, 1);
            2:       ready_next = (stall_phase == 0);
            default: ready_next = ($urandom_range(0, 3) == 0);
         endcase
         rsp_tready <= ready_next;
      end
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
